@@ rtl/core/wev_pkg.sv @@
package wev_pkg;

	// Defaults and fixed-point constants
	localparam int DIMENSION_DEF = 3;
	localparam int MANT_BITS     = 12;
	localparam logic [15:0] CW_RESET = 16'd16384;
	// floor(x / 6) = (x * RECIP6) >> 34 for any 32-bit x
	localparam logic [31:0] RECIP6   = 32'hAAAA_AAAB;
	localparam int RECIP6_SHIFT      = 34;

	// Input transfer: one cell
	typedef struct packed {
		logic signed [31:0] grad_11;
		logic signed [31:0] grad_12;
		logic signed [31:0] grad_13;
		logic signed [31:0] grad_21;
		logic signed [31:0] grad_22;
		logic signed [31:0] grad_23;
		logic signed [31:0] grad_31;
		logic signed [31:0] grad_32;
		logic signed [31:0] grad_33;
		logic [23:0]        filter_length;
	} cell_t;

	// Output transfer: one viscosity
	typedef struct packed {
		logic [31:0] eddy_viscosity;
		logic        saturated;
	} visc_t;

	// Lane arithmetic widths
	typedef logic signed [MANT_BITS:0]   h_t;    // normalized gradient
	typedef logic signed [MANT_BITS+1:0] e_t;    // h_ij + h_ji
	typedef logic signed [27:0]          g_t;    // element of h*h
	typedef logic signed [29:0]          tr_t;   // trace of h*h
	typedef logic signed [31:0]          t_t;    // 6 * sd element
	typedef logic [63:0]                 sq_t;   // T^2
	typedef logic [27:0]                 esq_t;  // e^2

endpackage

@@ rtl/core/wev_lane.sv @@
// One tensor element: G_ij and e_ij, then T_ij and e_ij^2, then T_ij^2.
module wev_lane #(
	parameter int NDIM    = 3,
	parameter bit IS_DIAG = 1'b0
) (
	input  logic            clk,
	input  logic            en,
	input  wev_pkg::h_t     h_row [NDIM],
	input  wev_pkg::h_t     h_col [NDIM],
	input  wev_pkg::h_t     h_ij,
	input  wev_pkg::h_t     h_ji,
	input  wev_pkg::g_t     g_ji,
	input  wev_pkg::tr_t    tr,
	output wev_pkg::g_t     g_ij,
	output wev_pkg::sq_t    t2,
	output wev_pkg::esq_t   e2
);

	wev_pkg::g_t  dot_c;
	wev_pkg::e_t  e_c;
	wev_pkg::g_t  g_s1;
	wev_pkg::e_t  e_s1;
	wev_pkg::t_t  tsum_c;
	wev_pkg::t_t  t_c;
	logic signed [27:0] esq_c;
	wev_pkg::t_t  t_s2;
	wev_pkg::esq_t e2_s2;
	logic signed [63:0] tsq_c;
	wev_pkg::sq_t t2_s3;
	wev_pkg::esq_t e2_s3;

	// row-times-column dot product
	always_comb begin
		dot_c = '0;
		for (int k = 0; k < NDIM; k++) begin
			dot_c = dot_c + wev_pkg::g_t'(h_row[k]) * wev_pkg::g_t'(h_col[k]);
		end
		e_c = wev_pkg::e_t'(h_ij) + wev_pkg::e_t'(h_ji);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= dot_c;
			e_s1 <= e_c;
		end
	end

	assign g_ij = g_s1;

	// T = 3(G_ij + G_ji) - 2 tr on the diagonal
	always_comb begin
		tsum_c = wev_pkg::t_t'(g_s1) + wev_pkg::t_t'(g_ji);
		t_c    = (tsum_c <<< 1) + tsum_c;
		if (IS_DIAG) begin
			t_c = t_c - (wev_pkg::t_t'(tr) <<< 1);
		end
	end

	assign esq_c = e_s1 * e_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2  <= t_c;
			e2_s2 <= $unsigned(esq_c);
		end
	end

	// squares, both non-negative
	assign tsq_c = t_s2 * t_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s3 <= $unsigned(tsq_c);
			e2_s3 <= e2_s2;
		end
	end

	assign t2 = t2_s3;
	assign e2 = e2_s3;

endmodule

@@ rtl/core/wev_isqrt.sv @@
// Pipelined floor square root, one root bit per stage.
module wev_isqrt #(
	parameter int RAD_W = 64,
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  logic [RAD_W-1:0]     rad,
	input  logic [TAG_W-1:0]     tag_in,
	output logic                 vld_out,
	output logic [RAD_W/2-1:0]   root,
	output logic [TAG_W-1:0]     tag_out
);

	localparam int N     = RAD_W / 2;
	localparam int REM_W = N + 3;

	logic [RAD_W-1:0] rad_s  [N+1];
	logic [REM_W-1:0] rem_s  [N+1];
	logic [N-1:0]     root_s [N+1];
	logic [TAG_W-1:0] tag_s  [N+1];
	logic             vld_s  [N+1];

	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = tag_in;
	assign vld_s[0]  = vld_in;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;

		// bring down two radicand bits, try root bit one
		assign cur   = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= tag_s[k];
				rad_s[k+1] <= rad_s[k] << 2;
				if (cur >= trial) begin
					rem_s[k+1]  <= cur - trial;
					root_s[k+1] <= {root_s[k][N-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= cur;
					root_s[k+1] <= {root_s[k][N-2:0], 1'b0};
				end
			end
		end
	end

	assign vld_out = vld_s[N];
	assign root    = root_s[N];
	assign tag_out = tag_s[N];

endmodule

@@ rtl/core/wev_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in Q_W bits.
module wev_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32,
	parameter int Q_W   = 17,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             vld_out,
	output logic [Q_W-1:0]   quo,
	output logic [TAG_W-1:0] tag_out
);

	logic [DEN_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0]   low_s [Q_W+1];
	logic [Q_W-1:0]   quo_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [TAG_W-1:0] tag_s [Q_W+1];
	logic             vld_s [Q_W+1];

	assign rem_s[0] = DEN_W'(num >> Q_W);
	assign low_s[0] = num[Q_W-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = vld_in;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W:0] cur;
		logic [DEN_W:0] dx;

		assign cur = {rem_s[k], low_s[k][Q_W-1]};
		assign dx  = {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= tag_s[k];
				den_s[k+1] <= den_s[k];
				low_s[k+1] <= low_s[k] << 1;
				if (cur >= dx) begin
					rem_s[k+1] <= DEN_W'(cur - dx);
					quo_s[k+1] <= {quo_s[k][Q_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= cur[DEN_W-1:0];
					quo_s[k+1] <= {quo_s[k][Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign vld_out = vld_s[Q_W];
	assign quo     = quo_s[Q_W];
	assign tag_out = tag_s[Q_W];

endmodule

@@ rtl/core/wale_eddy_viscosity.sv @@
// Channel   | Dir | Handshake                 | Payload
// ----------+-----+---------------------------+-----------------------------
// cell      | in  | cell_valid / cell_stall   | wev_pkg::cell_t (9 grads, l)
// visc      | out | visc_valid / visc_stall   | wev_pkg::visc_t
// cfg       | in  | cfg_valid / cfg_ready     | cfg_data = cw, Q1.15
//
// One cell per cycle while cell_stall is low; each result passes through the two chained
// 32-stage square roots and the two 17-stage dividers before it is offered.
// arst_n clears all valid flags and sets cw to 0.5; no clearing pass is needed.
// A result refused by the receiver moves into a skid register; from the next cycle
// the whole pipeline and cell_stall hold until that result is taken.
module wale_eddy_viscosity #(
	parameter int DIMENSION = wev_pkg::DIMENSION_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cell_valid,
	output logic            cell_stall,
	input  wev_pkg::cell_t  cell_data,
	output logic            visc_valid,
	input  logic            visc_stall,
	output wev_pkg::visc_t  visc,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);

	localparam int DIMS = (DIMENSION < 3) ? 2 : 3;
	localparam int MB   = wev_pkg::MANT_BITS;

	logic        en;
	logic [15:0] c_q;

	// front end
	wev_pkg::cell_t cell_s1;
	logic           v_s1;
	logic [31:0]    raw_c   [3][3];
	logic [31:0]    mag_c   [DIMS][DIMS];
	logic [31:0]    or_c;
	logic [5:0]     n_c;
	logic [4:0]     s_c;
	logic [31:0]    mag_s2  [DIMS][DIMS];
	logic           neg_s2  [DIMS][DIMS];
	logic [4:0]     s_s2;
	logic [23:0]    l_s2;
	logic           v_s2;
	wev_pkg::h_t    h_c     [DIMS][DIMS];
	wev_pkg::h_t    h_s3    [DIMS][DIMS];
	wev_pkg::h_t    hcol_s3 [DIMS][DIMS];
	logic [4:0]     s_s3, s_s4, s_s5, s_s6, s_s7, s_s8;
	logic [23:0]    l_s3, l_s4, l_s5, l_s6, l_s7, l_s8;
	logic           v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// lanes and merge
	wev_pkg::g_t    g_s4  [DIMS][DIMS];
	wev_pkg::tr_t   tr_s4;
	wev_pkg::sq_t   t2_s6 [DIMS][DIMS];
	wev_pkg::esq_t  e2_s6 [DIMS][DIMS];
	logic [63:0]    qrow_s7 [DIMS];
	logic [31:0]    prow_s7 [DIMS];
	logic [63:0]    q_s8;
	logic [31:0]    p_s8;

	// roots
	logic           v_s40;
	logic [31:0]    root_s40;
	logic [60:0]    tag_s40;
	logic [63:0]    wprod_c;
	logic [29:0]    w_s41;
	logic [31:0]    p_s41;
	logic [23:0]    l_s41;
	logic [4:0]     s_s41;
	logic           v_s41;
	logic           v_s73;
	logic [31:0]    a_s73, b_s73;
	logic [28:0]    tag_s73;
	logic [31:0]    a_s74;
	logic           sel_s74;
	logic [47:0]    num_s74;
	logic [31:0]    den_s74;
	logic [23:0]    l_s74;
	logic [4:0]     s_s74;
	logic           v_s74;

	// ratio and fifth power
	logic           v_s91;
	logic [16:0]    x_s91;
	logic [61:0]    tag_s91;
	logic [33:0]    x2p_c, x4p_c, p5p_c;
	logic [16:0]    x_s92, x_s93, x2_s92, x4_s93, p5_s94;
	logic [31:0]    a_s92, a_s93, a_s94;
	logic           sel_s92, sel_s93, sel_s94;
	logic [23:0]    l_s92, l_s93, l_s94;
	logic [4:0]     s_s92, s_s93, s_s94;
	logic           v_s92, v_s93, v_s94;
	logic [32:0]    num2_c;
	logic [17:0]    den2_c;
	logic           v_s111;
	logic [16:0]    f_s111;
	logic [60:0]    tag_s111;
	logic [31:0]    a_s111;

	// scaling
	logic [48:0]    rprod_c;
	logic [47:0]    z1prod_c, z2prod_c;
	logic [56:0]    z3prod_c, z4prod_c;
	logic [31:0]    r_s112, z1_s113;
	logic [32:0]    z2_s114, z3_s115, z4_s116;
	logic           az_s112, az_s113, az_s114, az_s115, az_s116;
	logic [23:0]    l_s112, l_s113, l_s114, l_s115;
	logic [4:0]     s_s112, s_s113, s_s114, s_s115, s_s116;
	logic           v_s112, v_s113, v_s114, v_s115, v_s116;
	logic [63:0]    zs_c;
	wev_pkg::visc_t res_c, res_q;
	logic           vout_q;
	wev_pkg::visc_t skid_q;
	logic           skid_v_q;

	// flow control: freeze the pipeline while the skid register is occupied
	assign en         = !skid_v_q;
	assign cell_stall = skid_v_q;
	assign cfg_ready  = 1'b1;
	assign visc_valid = vout_q || skid_v_q;
	assign visc       = skid_v_q ? skid_q : res_q;

	// skid register: keeps a refused result while the pipeline steps once more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			skid_v_q <= visc_stall;
		end else begin
			skid_v_q <= vout_q && visc_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && vout_q && visc_stall) begin
			skid_q <= res_q;
		end
	end

	// model constant register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= wev_pkg::CW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			c_q <= cfg_data;
		end
	end

	// valid pipeline of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s41 <= 1'b0; v_s74 <= 1'b0;
			v_s92 <= 1'b0; v_s93 <= 1'b0; v_s94 <= 1'b0;
			v_s112 <= 1'b0; v_s113 <= 1'b0; v_s114 <= 1'b0;
			v_s115 <= 1'b0; v_s116 <= 1'b0;
			vout_q <= 1'b0;
		end else if (en) begin
			v_s1 <= cell_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s41 <= v_s40; v_s74 <= v_s73;
			v_s92 <= v_s91; v_s93 <= v_s92; v_s94 <= v_s93;
			v_s112 <= v_s111; v_s113 <= v_s112; v_s114 <= v_s113;
			v_s115 <= v_s114; v_s116 <= v_s115;
			vout_q <= v_s116;
		end
	end

	// S1: input register
	always_ff @(posedge clk) begin
		if (en) begin
			cell_s1 <= cell_data;
		end
	end

	assign raw_c[0][0] = cell_s1.grad_11;
	assign raw_c[0][1] = cell_s1.grad_12;
	assign raw_c[0][2] = cell_s1.grad_13;
	assign raw_c[1][0] = cell_s1.grad_21;
	assign raw_c[1][1] = cell_s1.grad_22;
	assign raw_c[1][2] = cell_s1.grad_23;
	assign raw_c[2][0] = cell_s1.grad_31;
	assign raw_c[2][1] = cell_s1.grad_32;
	assign raw_c[2][2] = cell_s1.grad_33;

	// magnitudes and block exponent (bit length of the OR equals that of the max)
	always_comb begin
		or_c = '0;
		for (int i = 0; i < DIMS; i++) begin
			for (int j = 0; j < DIMS; j++) begin
				mag_c[i][j] = raw_c[i][j][31] ? (~raw_c[i][j] + 32'd1) : raw_c[i][j];
				or_c        = or_c | mag_c[i][j];
			end
		end
		n_c = '0;
		for (int b = 0; b < 32; b++) begin
			if (or_c[b]) begin
				n_c = 6'(b + 1);
			end
		end
		s_c = (n_c > 6'(MB)) ? 5'(n_c - 6'(MB)) : '0;
	end

	// S2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIMS; i++) begin
				for (int j = 0; j < DIMS; j++) begin
					mag_s2[i][j] <= mag_c[i][j];
					neg_s2[i][j] <= raw_c[i][j][31];
				end
			end
			s_s2 <= s_c;
			l_s2 <= cell_s1.filter_length;
		end
	end

	// S3: normalized signed mantissas
	always_comb begin
		for (int i = 0; i < DIMS; i++) begin
			for (int j = 0; j < DIMS; j++) begin
				h_c[i][j] = $signed({1'b0, MB'(mag_s2[i][j] >> s_s2)});
				if (neg_s2[i][j]) begin
					h_c[i][j] = -h_c[i][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s3 <= h_c;
			s_s3 <= s_s2; l_s3 <= l_s2;
			s_s4 <= s_s3; l_s4 <= l_s3;
			s_s5 <= s_s4; l_s5 <= l_s4;
			s_s6 <= s_s5; l_s6 <= l_s5;
			s_s7 <= s_s6; l_s7 <= l_s6;
			s_s8 <= s_s7; l_s8 <= l_s7;
		end
	end

	always_comb begin
		for (int i = 0; i < DIMS; i++) begin
			for (int j = 0; j < DIMS; j++) begin
				hcol_s3[j][i] = h_s3[i][j];
			end
		end
	end

	// trace of h*h from the lanes' first stage
	always_comb begin
		tr_s4 = '0;
		for (int i = 0; i < DIMS; i++) begin
			tr_s4 = tr_s4 + wev_pkg::tr_t'(g_s4[i][i]);
		end
	end

	// element lanes, S4 to S6
	for (genvar i = 0; i < DIMS; i++) begin : g_row
		for (genvar j = 0; j < DIMS; j++) begin : g_col
			wev_lane #(
				.NDIM    (DIMS),
				.IS_DIAG (i == j)
			) u_lane (
				.clk   (clk),
				.en    (en),
				.h_row (h_s3[i]),
				.h_col (hcol_s3[j]),
				.h_ij  (h_s3[i][j]),
				.h_ji  (h_s3[j][i]),
				.g_ji  (g_s4[j][i]),
				.tr    (tr_s4),
				.g_ij  (g_s4[i][j]),
				.t2    (t2_s6[i][j]),
				.e2    (e2_s6[i][j])
			);
		end
	end

	// merge: row sums, then total
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIMS; i++) begin
				qrow_s7[i] <= t2_s6[i][0] + t2_s6[i][1]
					+ ((DIMS > 2) ? t2_s6[i][DIMS-1] : 64'd0);
				prow_s7[i] <= 32'(e2_s6[i][0]) + 32'(e2_s6[i][1])
					+ ((DIMS > 2) ? 32'(e2_s6[i][DIMS-1]) : 32'd0);
			end
			q_s8 <= qrow_s7[0] + qrow_s7[1] + ((DIMS > 2) ? qrow_s7[DIMS-1] : 64'd0);
			p_s8 <= prow_s7[0] + prow_s7[1] + ((DIMS > 2) ? prow_s7[DIMS-1] : 32'd0);
		end
	end

	// isqrt(q); isqrt(q / 36) = isqrt(q) / 6
	wev_isqrt #(
		.RAD_W (64),
		.TAG_W (61)
	) u_sqrt_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s8),
		.rad     (q_s8),
		.tag_in  ({p_s8, l_s8, s_s8}),
		.vld_out (v_s40),
		.root    (root_s40),
		.tag_out (tag_s40)
	);

	assign wprod_c = root_s40 * wev_pkg::RECIP6;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s41 <= wprod_c[wev_pkg::RECIP6_SHIFT +: 30];
			p_s41 <= tag_s40[60:29];
			l_s41 <= tag_s40[28:5];
			s_s41 <= tag_s40[4:0];
		end
	end

	// a = sd2^(1/4) and b = S2^(1/2), side by side
	wev_isqrt #(
		.RAD_W (64),
		.TAG_W (29)
	) u_sqrt_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s41),
		.rad     ({2'b00, w_s41, 32'h0}),
		.tag_in  ({l_s41, s_s41}),
		.vld_out (v_s73),
		.root    (a_s73),
		.tag_out (tag_s73)
	);

	wev_isqrt #(
		.RAD_W (64),
		.TAG_W (1)
	) u_sqrt_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s41),
		.rad     ({2'b00, p_s41, 30'h0}),
		.tag_in  (1'b0),
		.vld_out (),
		.root    (b_s73),
		.tag_out ()
	);

	// ratio operands: smaller over larger
	always_ff @(posedge clk) begin
		if (en) begin
			a_s74   <= a_s73;
			sel_s74 <= (b_s73 <= a_s73);
			num_s74 <= (b_s73 <= a_s73) ? {b_s73, 16'h0} : {a_s73, 16'h0};
			den_s74 <= (b_s73 <= a_s73) ? a_s73 : b_s73;
			l_s74   <= tag_s73[28:5];
			s_s74   <= tag_s73[4:0];
		end
	end

	wev_div #(
		.NUM_W (48),
		.DEN_W (32),
		.Q_W   (17),
		.TAG_W (62)
	) u_div_ratio (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s74),
		.num     (num_s74),
		.den     (den_s74),
		.tag_in  ({a_s74, sel_s74, l_s74, s_s74}),
		.vld_out (v_s91),
		.quo     (x_s91),
		.tag_out (tag_s91)
	);

	// fifth power in Q.16, one product per stage
	assign x2p_c = x_s91 * x_s91;
	assign x4p_c = x2_s92 * x2_s92;
	assign p5p_c = x4_s93 * x_s93;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s92  <= x2p_c[32:16];
			x_s92   <= x_s91;
			a_s92   <= tag_s91[61:30];
			sel_s92 <= tag_s91[29];
			l_s92   <= tag_s91[28:5];
			s_s92   <= tag_s91[4:0];
			x4_s93  <= x4p_c[32:16];
			x_s93   <= x_s92;
			a_s93   <= a_s92; sel_s93 <= sel_s92; l_s93 <= l_s92; s_s93 <= s_s92;
			p5_s94  <= p5p_c[32:16];
			a_s94   <= a_s93; sel_s94 <= sel_s93; l_s94 <= l_s93; s_s94 <= s_s93;
		end
	end

	// f = a^5 / (a^5 + b^5) in Q1.16
	assign num2_c = sel_s94 ? 33'h1_0000_0000 : {p5_s94, 16'h0};
	assign den2_c = 18'h1_0000 + {1'b0, p5_s94};

	wev_div #(
		.NUM_W (33),
		.DEN_W (18),
		.Q_W   (17),
		.TAG_W (61)
	) u_div_frac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (v_s94),
		.num     (num2_c),
		.den     (den2_c),
		.tag_in  ({a_s94, l_s94, s_s94}),
		.vld_out (v_s111),
		.quo     (f_s111),
		.tag_out (tag_s111)
	);

	assign a_s111 = tag_s111[60:29];

	// scale by a, cw twice, l twice
	assign rprod_c  = a_s111 * f_s111;
	assign z1prod_c = r_s112 * c_q;
	assign z2prod_c = z1_s113 * c_q;
	assign z3prod_c = z2_s114 * l_s114;
	assign z4prod_c = z3_s115 * l_s115;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s112  <= rprod_c[47:16];
			az_s112 <= (a_s111 == '0);
			l_s112  <= tag_s111[28:5];
			s_s112  <= tag_s111[4:0];
			z1_s113 <= z1prod_c[46:15];
			az_s113 <= az_s112; l_s113 <= l_s112; s_s113 <= s_s112;
			z2_s114 <= z2prod_c[47:15];
			az_s114 <= az_s113; l_s114 <= l_s113; s_s114 <= s_s113;
			z3_s115 <= z3prod_c[56:24];
			az_s115 <= az_s114; l_s115 <= l_s114; s_s115 <= s_s114;
			z4_s116 <= z4prod_c[56:24];
			az_s116 <= az_s115; s_s116 <= s_s115;
		end
	end

	// undo normalization, saturate; zero result when cw or a is zero
	always_comb begin
		zs_c = {31'h0, z4_s116} << s_s116;
		if (c_q == '0 || az_s116) begin
			res_c.eddy_viscosity = '0;
			res_c.saturated      = 1'b0;
		end else if (|zs_c[63:32]) begin
			res_c.eddy_viscosity = 32'hFFFF_FFFF;
			res_c.saturated      = 1'b1;
		end else begin
			res_c.eddy_viscosity = zs_c[31:0];
			res_c.saturated      = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
		end
	end

	// checks
	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		visc_valid && visc.saturated |-> visc.eddy_viscosity == 32'hFFFF_FFFF)
		else $error("saturated result is not all ones");

	a_cw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		visc_valid && c_q == '0 |-> visc.eddy_viscosity == '0 && !visc.saturated)
		else $error("nonzero result with zero model constant");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s41) && $stable(v_s74) && $stable(v_s116))
		else $error("pipeline moved while frozen");

endmodule
